// ===== design/iwm_pkg.sv =====
// ----------------------------------------------------------------------------
// iwm_pkg: shared types and codes for the interval window merge block
// Item structs, operation modes and result status codes.
// ----------------------------------------------------------------------------
package iwm_pkg;

    localparam int MAX_WINDOWS_DEF = 256;
    localparam int COORD_BITS_DEF  = 32;
    localparam int FIELD_BITS      = 32;

    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_LOOKUP = 2'd1;
    localparam logic [1:0] MODE_READ   = 2'd2;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_MISS = 2'd2;

    typedef struct packed {
        logic [1:0]            mode;
        logic [FIELD_BITS-1:0] iv_start;
        logic [FIELD_BITS-1:0] iv_end;
        logic [7:0]            read_index;
    } req_item_t;

    typedef struct packed {
        logic [1:0]            status;
        logic [7:0]            win_index;
        logic [FIELD_BITS-1:0] win_start;
        logic [FIELD_BITS-1:0] win_end;
        logic [8:0]            win_count;
    } rsp_item_t;

endpackage

// ===== design/interval_window_merge.sv =====
// ----------------------------------------------------------------------------
// interval_window_merge: sorted table of disjoint closed intervals
// Insert merges or places an interval, lookup finds the first containing
// window, read returns a window by index.
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  req     | in        | req_valid/req_stall | iwm_pkg req_item_t
//  rsp     | out       | rsp_valid/rsp_stall | iwm_pkg rsp_item_t
//
//  One item at a time; the window memory has one read and one write port.
//  Insert scans the table for the first window it touches, then either shifts
//  the later windows up to place the new one or moves them down over those it
//  absorbed. Lookup scans the windows in order; read fetches one by index.
//  Reset empties the table at once (count only, memory is not cleared).
//  A stalled result holds in the output register; the next item is taken
//  while it waits, and its own result waits for that register to drain.
// ----------------------------------------------------------------------------
module interval_window_merge #(
    parameter int MAX_WINDOWS = iwm_pkg::MAX_WINDOWS_DEF,
    parameter int COORD_BITS  = iwm_pkg::COORD_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  iwm_pkg::req_item_t req,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output iwm_pkg::rsp_item_t rsp
);

    localparam int FB   = iwm_pkg::FIELD_BITS;
    localparam int CW   = (COORD_BITS < FB) ? COORD_BITS : FB;
    localparam int EW   = 2 * CW;
    localparam int IW   = $clog2(MAX_WINDOWS);
    localparam int CNTW = $clog2(MAX_WINDOWS + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_LO_RD, S_LO_CHK, S_HI_CHK, S_HI_RD, S_DECIDE,
        S_SH_RD, S_SH_WR, S_CP_RD, S_CP_WR, S_LK_RD, S_LK_CHK,
        S_RD_WAIT, S_DONE
    } state_t;

    state_t              state_reg;
    logic [CNTW-1:0]     idx_reg;
    logic [CNTW-1:0]     lo_reg;
    logic [CNTW-1:0]     rem_reg;
    logic [CNTW-1:0]     total_reg;
    logic [CW-1:0]       s_reg, e_reg, ms_reg, me_reg;
    logic [1:0]          res_status_reg;
    logic [CNTW-1:0]     res_index_reg;
    logic [CW-1:0]       res_start_reg, res_end_reg;
    logic                rsp_valid_reg;
    iwm_pkg::rsp_item_t  rsp_reg;

    logic [EW-1:0]       mem [MAX_WINDOWS];
    logic [EW-1:0]       rd_data_reg;
    logic                mem_we;
    logic [IW-1:0]       mem_waddr, mem_raddr;
    logic [EW-1:0]       mem_wdata;

    logic [CW-1:0]       a_in, b_in, s_in, e_in;
    logic [CW-1:0]       rd_start, rd_end, me_fin;
    logic                ri_ok;

    assign a_in     = CW'(req.iv_start);
    assign b_in     = CW'(req.iv_end);
    assign s_in     = (b_in < a_in) ? b_in : a_in;
    assign e_in     = (b_in < a_in) ? a_in : b_in;
    assign rd_start = rd_data_reg[EW-1:CW];
    assign rd_end   = rd_data_reg[CW-1:0];
    assign me_fin   = (me_reg > e_reg) ? me_reg : e_reg;
    assign ri_ok    = (32'(req.read_index) < 32'(total_reg));

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // memory port control
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = IW'(idx_reg);
        mem_wdata = rd_data_reg;
        mem_raddr = IW'(idx_reg);
        case (state_reg)
            S_IDLE:    mem_raddr = IW'(req.read_index);
            S_DECIDE:
            begin
                mem_we    = (idx_reg != lo_reg);
                mem_waddr = IW'(lo_reg);
                mem_wdata = {ms_reg, me_fin};
            end
            S_SH_RD:
            begin
                mem_raddr = IW'(idx_reg - CNTW'(1));
                mem_we    = (idx_reg == lo_reg);
                mem_waddr = IW'(lo_reg);
                mem_wdata = {s_reg, e_reg};
            end
            S_SH_WR:   mem_we = 1'b1;
            S_CP_WR:
            begin
                mem_we    = 1'b1;
                mem_waddr = IW'(idx_reg - rem_reg);
            end
            default:   mem_we = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            total_reg     <= '0;
            rsp_valid_reg <= 1'b0;
            idx_reg       <= '0;
            lo_reg        <= '0;
            rem_reg       <= '0;
        end
        else
        begin
            // drop the valid after a transfer unless a new result loads now
            if (rsp_valid_reg && !rsp_stall && state_reg != S_DONE)
            begin
                rsp_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (req_valid)
                    begin
                        s_reg          <= s_in;
                        e_reg          <= e_in;
                        idx_reg        <= '0;
                        res_status_reg <= iwm_pkg::ST_MISS;
                        res_index_reg  <= '0;
                        res_start_reg  <= '0;
                        res_end_reg    <= '0;
                        case (req.mode)
                            iwm_pkg::MODE_INSERT: state_reg <= S_LO_RD;
                            iwm_pkg::MODE_LOOKUP: state_reg <= S_LK_RD;
                            iwm_pkg::MODE_READ:
                            begin
                                idx_reg   <= CNTW'(req.read_index);
                                state_reg <= ri_ok ? S_RD_WAIT : S_DONE;
                            end
                            default:              state_reg <= S_DONE;
                        endcase
                    end
                end
                S_LO_RD:
                begin
                    if (idx_reg == total_reg)
                    begin
                        lo_reg    <= idx_reg;
                        state_reg <= S_DECIDE;
                    end
                    else
                    begin
                        state_reg <= S_LO_CHK;
                    end
                end
                S_LO_CHK:
                begin
                    if (rd_end < s_reg)
                    begin
                        idx_reg   <= idx_reg + CNTW'(1);
                        state_reg <= S_LO_RD;
                    end
                    else
                    begin
                        lo_reg    <= idx_reg;
                        ms_reg    <= (rd_start < s_reg) ? rd_start : s_reg;
                        state_reg <= S_HI_CHK;
                    end
                end
                S_HI_CHK:
                begin
                    if (rd_start <= e_reg)
                    begin
                        me_reg    <= rd_end;
                        idx_reg   <= idx_reg + CNTW'(1);
                        state_reg <= S_HI_RD;
                    end
                    else
                    begin
                        state_reg <= S_DECIDE;
                    end
                end
                S_HI_RD:
                begin
                    state_reg <= (idx_reg == total_reg) ? S_DECIDE : S_HI_CHK;
                end
                S_DECIDE:
                begin
                    if (idx_reg == lo_reg)
                    begin
                        if (total_reg == CNTW'(MAX_WINDOWS))
                        begin
                            res_status_reg <= iwm_pkg::ST_FULL;
                            state_reg      <= S_DONE;
                        end
                        else
                        begin
                            idx_reg   <= total_reg;
                            state_reg <= S_SH_RD;
                        end
                    end
                    else
                    begin
                        res_status_reg <= iwm_pkg::ST_OK;
                        res_index_reg  <= lo_reg;
                        res_start_reg  <= ms_reg;
                        res_end_reg    <= me_fin;
                        rem_reg        <= idx_reg - lo_reg - CNTW'(1);
                        state_reg      <= S_CP_RD;
                    end
                end
                S_SH_RD:
                begin
                    if (idx_reg == lo_reg)
                    begin
                        total_reg      <= total_reg + CNTW'(1);
                        res_status_reg <= iwm_pkg::ST_OK;
                        res_index_reg  <= lo_reg;
                        res_start_reg  <= s_reg;
                        res_end_reg    <= e_reg;
                        state_reg      <= S_DONE;
                    end
                    else
                    begin
                        state_reg <= S_SH_WR;
                    end
                end
                S_SH_WR:
                begin
                    idx_reg   <= idx_reg - CNTW'(1);
                    state_reg <= S_SH_RD;
                end
                S_CP_RD:
                begin
                    // skip the move pass when nothing was absorbed
                    if (idx_reg == total_reg || rem_reg == '0)
                    begin
                        total_reg <= total_reg - rem_reg;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        state_reg <= S_CP_WR;
                    end
                end
                S_CP_WR:
                begin
                    idx_reg   <= idx_reg + CNTW'(1);
                    state_reg <= S_CP_RD;
                end
                S_LK_RD:
                begin
                    state_reg <= (idx_reg == total_reg) ? S_DONE : S_LK_CHK;
                end
                S_LK_CHK:
                begin
                    if (rd_start <= s_reg && rd_end >= e_reg)
                    begin
                        res_status_reg <= iwm_pkg::ST_OK;
                        res_index_reg  <= idx_reg;
                        res_start_reg  <= rd_start;
                        res_end_reg    <= rd_end;
                        state_reg      <= S_DONE;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + CNTW'(1);
                        state_reg <= S_LK_RD;
                    end
                end
                S_RD_WAIT:
                begin
                    res_status_reg <= iwm_pkg::ST_OK;
                    res_index_reg  <= idx_reg;
                    res_start_reg  <= rd_start;
                    res_end_reg    <= rd_end;
                    state_reg      <= S_DONE;
                end
                S_DONE:
                begin
                    // hold until the output register is free
                    if (!rsp_valid_reg || !rsp_stall)
                    begin
                        rsp_reg.status    <= res_status_reg;
                        rsp_reg.win_index <= 8'(res_index_reg);
                        rsp_reg.win_start <= FB'(res_start_reg);
                        rsp_reg.win_end   <= FB'(res_end_reg);
                        rsp_reg.win_count <= 9'(total_reg);
                        rsp_valid_reg     <= 1'b1;
                        state_reg         <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(total_reg) <= MAX_WINDOWS)
        else $error("window count above capacity");

    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> state_reg != S_IDLE)
        else $error("memory write while idle");

    a_full_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && res_status_reg == iwm_pkg::ST_FULL)
            |-> total_reg == CNTW'(MAX_WINDOWS))
        else $error("full status with free entries");

    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> state_reg != S_IDLE)
        else $error("item taken but block idle");

endmodule

// ===== tb/interval_window_merge_test.sv =====
// ----------------------------------------------------------------------------
// interval_window_merge_test: self-checking bench for interval_window_merge
// Drives inserts, lookups, reads and unused-mode items over the valid/stall
// request channel, predicts each result from a private copy of the window
// table, and compares every transfer on the result channel field by field.
// ----------------------------------------------------------------------------
module interval_window_merge_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_DEPTH  = iwm_pkg::MAX_WINDOWS_DEF;
    localparam int RANDOM_ITEMS = 2000;
    localparam int DRAIN_CYCLES = 1200;
    localparam int STALL_LIMIT  = 40000;

    // Window table predictor plus the queue of results still owed.
    class window_scoreboard;
        logic [31:0]        starts[TABLE_DEPTH];
        logic [31:0]        ends[TABLE_DEPTH];
        int                 total;
        iwm_pkg::rsp_item_t pending[$];
        int                 errors;
        int                 merges;
        int                 drops;
        int                 misses;
        int                 checked;

        function void reset_table();
            total   = 0;
            errors  = 0;
            merges  = 0;
            drops   = 0;
            misses  = 0;
            checked = 0;
            pending.delete();
        endfunction

        function iwm_pkg::rsp_item_t make_result(logic [1:0] st, int idx, logic [31:0] ws,
                                                 logic [31:0] we);
            iwm_pkg::rsp_item_t r;
            r.status    = st;
            r.win_index = idx[7:0];
            r.win_start = ws;
            r.win_end   = we;
            r.win_count = total[8:0];
            return r;
        endfunction

        function iwm_pkg::rsp_item_t insert_window(logic [31:0] s, logic [31:0] e);
            int          lo;
            int          hi;
            int          gone;
            logic [31:0] ms;
            logic [31:0] me;
            lo = 0;
            while (lo < total && ends[lo] < s)
                lo++;
            hi = lo;
            while (hi < total && starts[hi] <= e)
                hi++;
            if (hi == lo) begin
                if (total >= TABLE_DEPTH) begin
                    drops++;
                    return make_result(iwm_pkg::ST_FULL, 0, '0, '0);
                end
                for (int i = total; i > lo; i--) begin
                    starts[i] = starts[i-1];
                    ends[i]   = ends[i-1];
                end
                starts[lo] = s;
                ends[lo]   = e;
                total++;
                return make_result(iwm_pkg::ST_OK, lo, s, e);
            end
            merges++;
            ms = (starts[lo] < s) ? starts[lo] : s;
            me = (ends[hi-1] > e) ? ends[hi-1] : e;
            starts[lo] = ms;
            ends[lo]   = me;
            gone = hi - lo - 1;
            if (gone > 0) begin
                for (int i = hi; i < total; i++) begin
                    starts[i-gone] = starts[i];
                    ends[i-gone]   = ends[i];
                end
                total -= gone;
            end
            return make_result(iwm_pkg::ST_OK, lo, ms, me);
        endfunction

        function void note_request(iwm_pkg::req_item_t q);
            logic [31:0]        s;
            logic [31:0]        e;
            iwm_pkg::rsp_item_t r;
            s = q.iv_start;
            e = q.iv_end;
            if (e < s) begin
                s = q.iv_end;
                e = q.iv_start;
            end
            r = make_result(iwm_pkg::ST_MISS, 0, '0, '0);
            if (q.mode == iwm_pkg::MODE_INSERT) begin
                r = insert_window(s, e);
            end else if (q.mode == iwm_pkg::MODE_LOOKUP) begin
                for (int i = 0; i < total; i++) begin
                    if (starts[i] <= s && ends[i] >= e) begin
                        r = make_result(iwm_pkg::ST_OK, i, starts[i], ends[i]);
                        break;
                    end
                end
            end else if (q.mode == iwm_pkg::MODE_READ) begin
                if (q.read_index < total)
                    r = make_result(iwm_pkg::ST_OK, q.read_index, starts[q.read_index],
                                    ends[q.read_index]);
            end
            if (r.status == iwm_pkg::ST_MISS)
                misses++;
            pending.push_back(r);
        endfunction

        function void check_response(iwm_pkg::rsp_item_t a);
            iwm_pkg::rsp_item_t x;
            checked++;
            if (pending.size() == 0) begin
                $error("result transfer with nothing pending: status %0d index %0d",
                       a.status, a.win_index);
                errors++;
                return;
            end
            x = pending.pop_front();
            if (a.status !== x.status) begin
                $error("status expected %0d actual %0d", x.status, a.status);
                errors++;
            end
            if (a.win_index !== x.win_index) begin
                $error("win_index expected %0d actual %0d", x.win_index, a.win_index);
                errors++;
            end
            if (a.win_start !== x.win_start) begin
                $error("win_start expected %0h actual %0h", x.win_start, a.win_start);
                errors++;
            end
            if (a.win_end !== x.win_end) begin
                $error("win_end expected %0h actual %0h", x.win_end, a.win_end);
                errors++;
            end
            if (a.win_count !== x.win_count) begin
                $error("win_count expected %0d actual %0d", x.win_count, a.win_count);
                errors++;
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               req_valid;
    logic               req_stall;
    iwm_pkg::req_item_t req;
    logic               rsp_valid;
    logic               rsp_stall;
    iwm_pkg::rsp_item_t rsp;

    window_scoreboard board;
    int               send_idle_pct;
    int               recv_stall_pct;
    int               quiet_cycles;

    interval_window_merge dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Result side: check each transfer, then pick the next stall level.
    initial
    begin
        rsp_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_valid && !rsp_stall)
                board.check_response(rsp);
            rsp_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Watchdog: count cycles in which neither channel moves a transfer.
    initial
    begin
        quiet_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
                $display("interval_window_merge: mismatch");
                $finish;
            end
        end
    end

    task automatic send_item(logic [1:0] mode, logic [31:0] s, logic [31:0] e,
                             logic [7:0] idx);
        iwm_pkg::req_item_t q;
        q.mode       = mode;
        q.iv_start   = s;
        q.iv_end     = e;
        q.read_index = idx;
        while ($urandom_range(99) < send_idle_pct) begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= q;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        board.note_request(q);
    endtask

    task automatic send_random_item();
        int          pick;
        int          w;
        logic [31:0] s;
        logic [31:0] e;
        logic [31:0] span;
        pick = $urandom_range(99);
        s = $urandom;
        e = $urandom;
        if (pick < 30) begin
            // scattered short window, grows the table
            span = $urandom_range(255);
            e = s + span;
            if (e < s)
                e = 32'hFFFF_FFFF;
            if ($urandom_range(9) == 0)
                send_item(iwm_pkg::MODE_INSERT, e, s, 8'($urandom));
            else
                send_item(iwm_pkg::MODE_INSERT, s, e, 8'($urandom));
        end else if (pick < 45) begin
            // clustered near zero, merges and touching neighbors
            s = $urandom_range(20000);
            e = s + $urandom_range(300);
            send_item(iwm_pkg::MODE_INSERT, s, e, 8'($urandom));
        end else if (pick < 47) begin
            send_item(iwm_pkg::MODE_INSERT, s, e, 8'($urandom));
        end else if (pick < 67) begin
            if (board.total > 0 && $urandom_range(3) != 0) begin
                w = $urandom_range(board.total - 1);
                s = board.starts[w] + $urandom_range(board.ends[w] - board.starts[w]);
                e = s + $urandom_range(board.ends[w] - s);
                if ($urandom_range(4) == 0)
                    e = board.ends[w] + 1;
            end
            send_item(iwm_pkg::MODE_LOOKUP, s, e, 8'($urandom));
        end else if (pick < 95) begin
            if (board.total > 0 && $urandom_range(4) != 0)
                w = $urandom_range(board.total - 1);
            else
                w = $urandom_range(255);
            send_item(iwm_pkg::MODE_READ, s, e, w[7:0]);
        end else begin
            send_item(iwm_pkg::MODE_UNUSED, s, e, 8'($urandom));
        end
    endtask

    initial
    begin
        board = new();
        board.reset_table();
        rst_n          = 1'b0;
        req_valid      = 1'b0;
        req            = '0;
        send_idle_pct  = 9;
        recv_stall_pct = 79;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: edges of the coordinate space, merges, misses, bad modes
        send_item(iwm_pkg::MODE_READ,   32'd0, 32'd0, 8'd0);
        send_item(iwm_pkg::MODE_LOOKUP, 32'd5, 32'd5, 8'd0);
        send_item(iwm_pkg::MODE_INSERT, 32'd10, 32'd20, 8'd0);
        send_item(iwm_pkg::MODE_INSERT, 32'd30, 32'd40, 8'd0);
        send_item(iwm_pkg::MODE_INSERT, 32'd60, 32'd50, 8'd0);
        send_item(iwm_pkg::MODE_INSERT, 32'd21, 32'd29, 8'd0);
        send_item(iwm_pkg::MODE_READ,   32'd0, 32'd0, 8'd2);
        send_item(iwm_pkg::MODE_INSERT, 32'd15, 32'd35, 8'd0);
        send_item(iwm_pkg::MODE_LOOKUP, 32'd14, 32'd12, 8'd0);
        send_item(iwm_pkg::MODE_LOOKUP, 32'd45, 32'd55, 8'd0);
        send_item(iwm_pkg::MODE_LOOKUP, 32'd8, 32'd12, 8'd0);
        send_item(iwm_pkg::MODE_INSERT, 32'd0, 32'd0, 8'd0);
        send_item(iwm_pkg::MODE_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd0);
        send_item(iwm_pkg::MODE_READ,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd255);
        send_item(iwm_pkg::MODE_READ,   32'd0, 32'd0, 8'd3);
        send_item(iwm_pkg::MODE_UNUSED, 32'hFFFF_FFFF, 32'd0, 8'hFF);
        send_item(iwm_pkg::MODE_INSERT, 32'd45, 32'hFFFF_FFF0, 8'd0);
        send_item(iwm_pkg::MODE_INSERT, 32'hFFFF_FFFF, 32'd0, 8'd0);
        send_item(iwm_pkg::MODE_LOOKUP, 32'd0, 32'hFFFF_FFFF, 8'd0);
        send_item(iwm_pkg::MODE_READ,   32'd0, 32'd0, 8'd1);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS / 3) begin
                send_idle_pct  = 79;
                recv_stall_pct = 9;
            end else if (n == 2 * RANDOM_ITEMS / 3) begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            send_random_item();
        end
        req_valid <= 1'b0;

        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d results: %0d merges, %0d dropped on full table, %0d misses",
                 board.checked, board.merges, board.drops, board.misses);
        $display("windows held at end: %0d", board.total);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("interval_window_merge: match");
        else
            $display("interval_window_merge: mismatch");
        $finish;
    end

endmodule
